### src/mwpl_pkg.sv
// ----------------------------------------------------------------------------
// mwpl_pkg: shared constants for the multi-wall path loss block
// fixed-point constants of the loss formula and parameter defaults
// ----------------------------------------------------------------------------
package mwpl_pkg;

    localparam int MAX_WALLS_DEF  = 16;
    localparam int COORD_BITS_DEF = 10;

    // beat kinds carried on tuser
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // log10(2) in q30
    localparam logic [28:0] LOG10_2_Q30  = 29'd323228497;
    // slopes in centi-db per decade, offsets in q16 centi-db
    localparam logic [9:0]  SLOPE_OPEN   = 10'd935;
    localparam logic [9:0]  SLOPE_WALLS  = 10'd1000;
    localparam logic [27:0] OFFSET_OPEN  = 28'd142375811;
    localparam logic [27:0] OFFSET_WALLS = 28'd131234691;
    // 12 db per wall in q16 centi-db
    localparam logic [26:0] WALL_STEP    = 27'd78643200;

    localparam int LOG_ROUNDS = 16;
    localparam int NEAR_D2    = 100;

endpackage

### src/mwpl_cross.sv
// ----------------------------------------------------------------------------
// mwpl_cross: wall table and crossing counter
// holds the wall table in a synchronous ram and tests one wall per cycle
// ----------------------------------------------------------------------------
module mwpl_cross #(
    parameter int MAX_WALLS  = mwpl_pkg::MAX_WALLS_DEF,
    parameter int COORD_BITS = mwpl_pkg::COORD_BITS_DEF,
    localparam int AW   = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1,
    localparam int CNTW = $clog2(MAX_WALLS + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic [4*COORD_BITS-1:0] wr_data,
    input  logic                    start,
    input  logic [CNTW-1:0]         used,
    input  logic [COORD_BITS-1:0]   tx,
    input  logic [COORD_BITS-1:0]   ty,
    input  logic [COORD_BITS-1:0]   rx,
    input  logic [COORD_BITS-1:0]   ry,
    output logic                    busy,
    output logic [CNTW-1:0]         count
);

    localparam int C  = COORD_BITS;
    localparam int SW = C + 1;
    localparam int PW = 2 * SW;
    localparam int CW = 3 * SW + 2;
    localparam int KW = PW + C;

    logic [4*C-1:0] mem [MAX_WALLS];
    logic [4*C-1:0] rd_data_reg;

    logic            issue_reg, issue_next;
    logic [CNTW-1:0] rd_cnt_reg, rd_cnt_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [4:0]      vld_reg;

    logic signed [SW-1:0] dxr, dyr;
    logic [C-1:0]         x1, y1, x2, y2;
    logic signed [SW-1:0] dxw, dyw;

    // stage 1
    logic signed [PW-1:0] a1_reg, a2_reg, a3_reg, b3_reg;
    logic [4*C-1:0]       w1_reg;
    // stage 2
    logic signed [CW-1:0] m1_reg, m2_reg, m3_reg, n1_reg, n2_reg, n3_reg;
    logic [PW-1:0]        k2_reg;
    logic [4*C-1:0]       w2_reg;
    // stage 3
    logic [CW-1:0]        c1_reg, c2_reg;
    logic [PW-1:0]        k3_reg;
    logic [4*C-1:0]       w3_reg;
    // stage 4
    logic [CW-1:0]        c1b_reg, c2b_reg;
    logic [KW-1:0]        ptlo_reg, pthi_reg, pwxlo_reg, pwxhi_reg;
    logic [KW-1:0]        ptylo_reg, ptyhi_reg, pwylo_reg, pwyhi_reg;

    logic [C-1:0]         w2x1, w2y1, w3x1, w3y1, w3x2, w3y2;
    logic signed [SW-1:0] ydiff, xdiff;
    logic signed [PW:0]   kdiff;
    logic signed [CW-1:0] c1s, c2s;
    logic                 hit;

    assign dxr = $signed({1'b0, rx}) - $signed({1'b0, tx});
    assign dyr = $signed({1'b0, ry}) - $signed({1'b0, ty});

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_cnt_reg[AW-1:0]];
    end

    // read issue
    always_comb
    begin
        issue_next  = issue_reg;
        rd_cnt_next = rd_cnt_reg;
        if (start)
        begin
            issue_next  = (used != '0);
            rd_cnt_next = '0;
        end
        else if (issue_reg)
        begin
            rd_cnt_next = rd_cnt_reg + 1'b1;
            if (rd_cnt_reg + 1'b1 == used)
            begin
                issue_next = 1'b0;
            end
        end
    end

    assign count_next = start ? '0 : (vld_reg[4] && hit) ? count_reg + 1'b1 : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg  <= 1'b0;
            rd_cnt_reg <= '0;
            count_reg  <= '0;
            vld_reg    <= '0;
        end
        else
        begin
            issue_reg  <= issue_next;
            rd_cnt_reg <= rd_cnt_next;
            count_reg  <= count_next;
            vld_reg    <= {vld_reg[3:0], issue_reg};
        end
    end

    assign busy  = issue_reg || (vld_reg != '0);
    assign count = count_reg;

    assign x1  = rd_data_reg[C-1:0];
    assign y1  = rd_data_reg[2*C-1:C];
    assign x2  = rd_data_reg[3*C-1:2*C];
    assign y2  = rd_data_reg[4*C-1:3*C];
    assign dxw = $signed({1'b0, x2}) - $signed({1'b0, x1});
    assign dyw = $signed({1'b0, y2}) - $signed({1'b0, y1});

    assign w2x1  = w1_reg[C-1:0];
    assign w2y1  = w1_reg[2*C-1:C];
    assign ydiff = $signed({1'b0, w2y1}) - $signed({1'b0, ty});
    assign xdiff = $signed({1'b0, tx}) - $signed({1'b0, w2x1});
    assign kdiff = (PW+1)'(a1_reg) - (PW+1)'(a2_reg);

    assign c1s = m1_reg - m2_reg + m3_reg;
    assign c2s = n1_reg - n2_reg + n3_reg;

    assign w3x1 = w3_reg[C-1:0];
    assign w3y1 = w3_reg[2*C-1:C];
    assign w3x2 = w3_reg[3*C-1:2*C];
    assign w3y2 = w3_reg[4*C-1:3*C];

    always_ff @(posedge clk)
    begin
        // direction products
        a1_reg <= PW'(dxw) * PW'(dyr);
        a2_reg <= PW'(dyw) * PW'(dxr);
        a3_reg <= PW'(dxr) * PW'(dxw);
        b3_reg <= PW'(dyr) * PW'(dyw);
        w1_reg <= rd_data_reg;

        // position products
        m1_reg <= CW'(a1_reg) * CW'($signed({1'b0, tx}));
        m2_reg <= CW'(a2_reg) * CW'($signed({1'b0, w2x1}));
        m3_reg <= CW'(a3_reg) * CW'(ydiff);
        n1_reg <= CW'(a1_reg) * CW'($signed({1'b0, w2y1}));
        n2_reg <= CW'(a2_reg) * CW'($signed({1'b0, ty}));
        n3_reg <= CW'(b3_reg) * CW'(xdiff);
        k2_reg <= kdiff[PW] ? PW'(-kdiff) : PW'(kdiff);
        w2_reg <= w1_reg;

        // magnitudes
        c1_reg <= c1s[CW-1] ? CW'(-c1s) : CW'(c1s);
        c2_reg <= c2s[CW-1] ? CW'(-c2s) : CW'(c2s);
        k3_reg <= k2_reg;
        w3_reg <= w2_reg;

        // scaled box bounds
        c1b_reg   <= c1_reg;
        c2b_reg   <= c2_reg;
        ptlo_reg  <= KW'(k3_reg) * KW'((tx < rx) ? tx : rx);
        pthi_reg  <= KW'(k3_reg) * KW'((tx < rx) ? rx : tx);
        pwxlo_reg <= KW'(k3_reg) * KW'((w3x1 < w3x2) ? w3x1 : w3x2);
        pwxhi_reg <= KW'(k3_reg) * KW'((w3x1 < w3x2) ? w3x2 : w3x1);
        ptylo_reg <= KW'(k3_reg) * KW'((ty < ry) ? ty : ry);
        ptyhi_reg <= KW'(k3_reg) * KW'((ty < ry) ? ry : ty);
        pwylo_reg <= KW'(k3_reg) * KW'((w3y1 < w3y2) ? w3y1 : w3y2);
        pwyhi_reg <= KW'(k3_reg) * KW'((w3y1 < w3y2) ? w3y2 : w3y1);
    end

    assign hit = (CW'(ptlo_reg) <= c1b_reg) && (c1b_reg <= CW'(pthi_reg)) &&
                 (CW'(pwxlo_reg) <= c1b_reg) && (c1b_reg <= CW'(pwxhi_reg)) &&
                 (CW'(ptylo_reg) <= c2b_reg) && (c2b_reg <= CW'(ptyhi_reg)) &&
                 (CW'(pwylo_reg) <= c2b_reg) && (c2b_reg <= CW'(pwyhi_reg));

endmodule

### src/multi_wall_path_loss.sv
// ----------------------------------------------------------------------------
// multi_wall_path_loss: multi-wall indoor path loss engine
// wall table loads and path loss queries over a stream, one beat at a time
// ----------------------------------------------------------------------------
// a load beat writes the wall table when accepted; a near-field query goes from the squared
// distance straight to the output; other queries normalize the squared distance, run the
//   log squaring rounds (one fraction bit each), then scale, sum and output the result;
//   the wall walk starts at the squared-distance step and runs beside the log, and the
//   scale step holds until the walk ends
// one beat in flight at a time; a waiting result does not block the next load
// reset clears control and walls_in_use; wall entries are undefined until loaded

module multi_wall_path_loss #(
    parameter int MAX_WALLS  = mwpl_pkg::MAX_WALLS_DEF,
    parameter int COORD_BITS = mwpl_pkg::COORD_BITS_DEF,
    localparam int DW = ((4 + 4 * COORD_BITS + 7) / 8) * 8
) (
    input  logic          clk,
    input  logic          rst_n,
    // slave stream
    input  logic          s_tvalid,
    output logic          s_tready,
    // wall_index, first_x, first_y, second_x, second_y, zero fill
    input  logic [DW-1:0] s_tdata,
    // kind
    input  logic          s_tuser,
    // master stream
    output logic          m_tvalid,
    input  logic          m_tready,
    // loss_centi_db, walls_crossed, near_field, zero fill
    output logic [23:0]   m_tdata,
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int C     = COORD_BITS;
    localparam int AW    = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CNTW  = $clog2(MAX_WALLS + 1);
    localparam int SW    = C + 1;
    localparam int D2W   = 2 * C + 1;
    localparam int KBW   = $clog2(D2W);
    localparam int LW    = KBW + 16;
    localparam int SCW   = LW + 9;
    localparam int TWA   = SCW + 2;
    localparam int TWB   = CNTW + 29;
    localparam int TW    = (TWA > TWB) ? TWA : TWB;
    localparam int RNDS  = mwpl_pkg::LOG_ROUNDS;
    localparam int RCW   = $clog2(RNDS);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SQ    = 9'b000000010,
        ST_D2    = 9'b000000100,
        ST_NORM  = 9'b000001000,
        ST_ROUND = 9'b000010000,
        ST_L10   = 9'b000100000,
        ST_SCALE = 9'b001000000,
        ST_SUM   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // input fields
    logic [3:0]   wall_index;
    logic [C-1:0] first_x, first_y, second_x, second_y;
    logic         kind;

    logic [4:0]   walls_in_use_reg;
    logic         cfg_wr;

    // query registers
    logic [C-1:0]     tx_reg, ty_reg, rx_reg, ry_reg;
    logic [2*C-1:0]   dxsq_reg, dysq_reg;
    logic [D2W-1:0]   norm_reg;
    logic [KBW-1:0]   k_reg;
    logic [31:0]      m_reg;
    logic [15:0]      frac_reg;
    logic [RCW-1:0]   rcnt_reg;
    logic [LW-1:0]    l10_reg;
    logic [SCW-1:0]   scaled_reg;
    logic [TW-1:0]    total_reg;
    logic             near_reg;

    // output register
    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;

    logic                  accept;
    logic                  walk_start, walk_busy;
    logic [CNTW-1:0]       used, walls_count;
    logic signed [SW-1:0]  dx, dy;
    logic [D2W-1:0]        d2;
    logic [D2W+30:0]       norm_ext;
    logic [63:0]           sq;
    logic [32:0]           sq_top;
    logic [LW+28:0]        l10_prod;
    logic [TW-1:0]         rnd;
    logic [15:0]           loss;
    logic [4:0]            crossed_sat;
    logic                  out_load;

    // field unpacking
    assign kind       = s_tuser;
    assign wall_index = s_tdata[3:0];
    assign first_x    = s_tdata[4+C-1:4];
    assign first_y    = s_tdata[4+2*C-1:4+C];
    assign second_x   = s_tdata[4+3*C-1:4+2*C];
    assign second_y   = s_tdata[4+4*C-1:4+3*C];

    // configuration port, register 0 at address 0, mirrored at addresses 1 to 3
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {27'd0, walls_in_use_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walls_in_use_reg <= '0;
        end
        else if (cfg_wr)
        begin
            walls_in_use_reg <= pwdata[4:0];
        end
    end

    // accept only while idle, one beat in flight
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // walls tested clamp at the table depth
    assign used = (32'(walls_in_use_reg) > MAX_WALLS) ? CNTW'(MAX_WALLS)
                                                     : CNTW'(walls_in_use_reg);

    mwpl_cross #(
        .MAX_WALLS  (MAX_WALLS),
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && (kind == mwpl_pkg::KIND_LOAD) && (32'(wall_index) < MAX_WALLS)),
        .wr_addr (AW'(wall_index)),
        .wr_data ({second_y, second_x, first_y, first_x}),
        .start   (walk_start),
        .used    (used),
        .tx      (tx_reg),
        .ty      (ty_reg),
        .rx      (rx_reg),
        .ry      (ry_reg),
        .busy    (walk_busy),
        .count   (walls_count)
    );

    // squared distance
    assign dx = $signed({1'b0, tx_reg}) - $signed({1'b0, rx_reg});
    assign dy = $signed({1'b0, ty_reg}) - $signed({1'b0, ry_reg});
    assign d2 = D2W'(dxsq_reg) + D2W'(dysq_reg);

    // normalized mantissa in q31 from the left-aligned squared distance
    assign norm_ext = {norm_reg, 31'd0};
    assign sq       = 64'(m_reg) * 64'(m_reg);
    assign sq_top   = sq[63:31];
    assign l10_prod = (LW+29)'({k_reg, frac_reg}) * (LW+29)'(mwpl_pkg::LOG10_2_Q30);

    assign walk_start = (state_reg == ST_D2) && (32'(d2) > mwpl_pkg::NEAR_D2);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind != mwpl_pkg::KIND_LOAD))
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                state_next = ST_D2;
            end
            ST_D2:
            begin
                state_next = walk_start ? ST_NORM : ST_DONE;
            end
            ST_NORM:
            begin
                if (norm_reg[D2W-1])
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rcnt_reg == '0)
                begin
                    state_next = ST_L10;
                end
            end
            ST_L10:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (!walk_busy)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                tx_reg <= first_x;
                ty_reg <= first_y;
                rx_reg <= second_x;
                ry_reg <= second_y;
            end
            ST_SQ:
            begin
                dxsq_reg <= (2*C)'((2*SW)'(dx) * (2*SW)'(dx));
                dysq_reg <= (2*C)'((2*SW)'(dy) * (2*SW)'(dy));
            end
            ST_D2:
            begin
                near_reg <= !walk_start;
                norm_reg <= d2;
                k_reg    <= KBW'(D2W - 1);
            end
            ST_NORM:
            begin
                // shift left until the top bit is set
                if (norm_reg[D2W-1])
                begin
                    m_reg    <= norm_ext[D2W+30:D2W-1];
                    frac_reg <= '0;
                    rcnt_reg <= RCW'(RNDS - 1);
                end
                else
                begin
                    norm_reg <= {norm_reg[D2W-2:0], 1'b0};
                    k_reg    <= k_reg - 1'b1;
                end
            end
            ST_ROUND:
            begin
                // square and renormalize, one fraction bit a round
                if (sq_top[32])
                begin
                    m_reg    <= sq_top[32:1];
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_reg    <= sq_top[31:0];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
                rcnt_reg <= rcnt_reg - 1'b1;
            end
            ST_L10:
            begin
                l10_reg <= LW'(l10_prod[LW+28:30]);
            end
            ST_SCALE:
            begin
                scaled_reg <= SCW'(l10_reg) * SCW'((walls_count == '0) ?
                              mwpl_pkg::SLOPE_OPEN : mwpl_pkg::SLOPE_WALLS);
            end
            ST_SUM:
            begin
                total_reg <= TW'(scaled_reg) +
                             TW'((walls_count == '0) ? mwpl_pkg::OFFSET_OPEN
                                                     : mwpl_pkg::OFFSET_WALLS) +
                             TW'(walls_count) * TW'(mwpl_pkg::WALL_STEP);
            end
            default:
            begin
            end
        endcase
    end

    // round half up, saturate
    assign rnd  = total_reg + TW'(32768);
    assign loss = (rnd[TW-1:16] > (TW-16)'(16'hffff)) ? 16'hffff : rnd[31:16];

    assign crossed_sat = (32'(walls_count) > 31) ? 5'd31 : 5'(walls_count);

    // output register frees the engine while a result waits
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (near_reg)
            begin
                m_tdata_reg <= {2'd0, 1'b1, 5'd0, 16'd0};
            end
            else
            begin
                m_tdata_reg <= {2'd0, 1'b0, crossed_sat, loss};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### tb/multi_wall_path_loss_tb.sv
// ----------------------------------------------------------------------------
// multi_wall_path_loss_tb: self-checking bench for the multi-wall path loss block
// loads wall tables and sends path queries over the input stream, with random
// idling on both sides, and compares every output beat against a scoreboard
// that computes crossings and the fixed-point loss on its own
// ----------------------------------------------------------------------------
module multi_wall_path_loss_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NWALLS   = mwpl_pkg::MAX_WALLS_DEF;
    localparam int DATA_W   = 48;
    localparam bit KIND_LOAD  = mwpl_pkg::KIND_LOAD;
    localparam bit KIND_QUERY = mwpl_pkg::KIND_QUERY;
    localparam logic [2:0] ADDR_WALLS_IN_USE = 3'd0;
    // settling time after the last result, longer than any query
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [15:0] loss;
        logic [4:0]  crossed;
        logic        near;
    } loss_beat_t;

    // ------------------------------------------------------------------
    // scoreboard: own copy of the wall table and the register
    // ------------------------------------------------------------------
    class path_loss_scoreboard;
        longint     wx1[NWALLS], wy1[NWALLS], wx2[NWALLS], wy2[NWALLS];
        int         walls_in_use;
        loss_beat_t expected_loss_q[$];
        int         mismatches;
        int         loads_seen, queries_seen, near_seen, crossed_seen;

        function new();
            walls_in_use = 0;
            mismatches = 0;
            loads_seen = 0;
            queries_seen = 0;
            near_seen = 0;
            crossed_seen = 0;
        endfunction

        static function longint sabs(longint v);
            return v < 0 ? -v : v;
        endfunction

        static function bit in_span(longint a, longint b, longint k, longint c);
            longint lo, hi;
            lo = a < b ? a : b;
            hi = a < b ? b : a;
            return (k * lo <= c) && (c <= k * hi);
        endfunction

        function bit wall_crossed(int w, longint tx, longint ty, longint rx, longint ry);
            longint dxr, dyr, dxw, dyw, c1, c2, k;
            dxr = rx - tx;
            dyr = ry - ty;
            dxw = wx2[w] - wx1[w];
            dyw = wy2[w] - wy1[w];
            // intersection point scaled by the cross product magnitude
            c1 = sabs(dxw * dyr * tx - dyw * dxr * wx1[w] + dxr * dxw * (wy1[w] - ty));
            c2 = sabs(dyr * dxw * wy1[w] - dxr * dyw * ty + dyr * dyw * (tx - wx1[w]));
            k  = sabs(dyr * dxw - dyw * dxr);
            return in_span(tx, rx, k, c1) && in_span(wx1[w], wx2[w], k, c1) &&
                   in_span(ty, ry, k, c2) && in_span(wy1[w], wy2[w], k, c2);
        endfunction

        // log2 in q16 by repeated squaring of the normalized mantissa
        static function longint log2_q16(bit [63:0] v);
            int          k;
            bit [63:0]   m;
            longint      res;
            k = 0;
            while (k < 63 && (v >> (k + 1)) != 0)
                k++;
            if (k <= 31)
                m = v << (31 - k);
            else
                m = v >> (k - 31);
            res = longint'(k) * 65536;
            for (int i = 15; i >= 0; i--)
            begin
                m = (m * m) >> 31;
                if (m >= 64'h1_0000_0000)
                begin
                    m = m >> 1;
                    res += longint'(1) << i;
                end
            end
            return res;
        endfunction

        function loss_beat_t predict_loss(longint fx, longint fy, longint sx, longint sy);
            loss_beat_t r;
            longint     dx, dy, d2, l10, total, loss;
            int         used, count;
            dx = fx - sx;
            dy = fy - sy;
            d2 = dx * dx + dy * dy;
            if (d2 <= mwpl_pkg::NEAR_D2)
            begin
                r.loss = 0;
                r.crossed = 0;
                r.near = 1'b1;
                return r;
            end
            used = walls_in_use > NWALLS ? NWALLS : walls_in_use;
            count = 0;
            for (int i = 0; i < used; i++)
                if (wall_crossed(i, fx, fy, sx, sy))
                    count++;
            l10 = (log2_q16(d2) * longint'(mwpl_pkg::LOG10_2_Q30)) >>> 30;
            if (count == 0)
                total = longint'(mwpl_pkg::SLOPE_OPEN) * l10
                        + longint'(mwpl_pkg::OFFSET_OPEN);
            else
                total = longint'(mwpl_pkg::SLOPE_WALLS) * l10
                        + longint'(mwpl_pkg::OFFSET_WALLS)
                        + longint'(count) * longint'(mwpl_pkg::WALL_STEP);
            if (total < 0)
                total = 0;
            loss = (total + 32768) >>> 16;
            if (loss > 65535)
                loss = 65535;
            r.loss = loss[15:0];
            r.crossed = count > 31 ? 5'd31 : count[4:0];
            r.near = 1'b0;
            return r;
        endfunction

        function void note_beat(bit kind, logic [DATA_W-1:0] d);
            int idx;
            idx = d[3:0];
            if (kind == KIND_LOAD)
            begin
                loads_seen++;
                if (idx < NWALLS)
                begin
                    wx1[idx] = d[13:4];
                    wy1[idx] = d[23:14];
                    wx2[idx] = d[33:24];
                    wy2[idx] = d[43:34];
                end
            end
            else
            begin
                queries_seen++;
                expected_loss_q.push_back(predict_loss(d[13:4], d[23:14], d[33:24], d[43:34]));
            end
        endfunction

        function void check_beat(logic [23:0] d);
            loss_beat_t exp_b, got;
            // beat layout: loss lowest, then crossed, then near
            got.loss    = d[15:0];
            got.crossed = d[20:16];
            got.near    = d[21];
            if (expected_loss_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected result beat %h", d);
                return;
            end
            exp_b = expected_loss_q.pop_front();
            if (exp_b.near)
                near_seen++;
            if (exp_b.crossed != 0)
                crossed_seen++;
            if (got !== exp_b || d[23:22] !== 2'b00)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: mismatch loss %0d/%0d crossed %0d/%0d near %0d/%0d (exp/got)",
                             exp_b.loss, got.loss, exp_b.crossed, got.crossed,
                             exp_b.near, got.near);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and signals
    // ------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    path_loss_scoreboard sb = new();
    bit idle_on = 1'b1;
    int settings_used = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    multi_wall_path_loss DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // result side: check each accepted beat, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata);
        m_tready <= idle_on ? ($urandom_range(99) >= 31) : 1'b1;
    end

    // hard stop in case the block hangs
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] pack_beat(int idx, int fx, int fy, int sx, int sy);
        logic [DATA_W-1:0] d;
        d = '0;
        d[3:0]   = idx[3:0];
        d[13:4]  = fx[9:0];
        d[23:14] = fy[9:0];
        d[33:24] = sx[9:0];
        d[43:34] = sy[9:0];
        return d;
    endfunction

    // one input beat; valid stays high into the next call unless it idles
    task automatic send_beat(bit kind, logic [DATA_W-1:0] d);
        while (idle_on && $urandom_range(99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_beat(kind, d);
    endtask

    task automatic send_load(int idx, int fx, int fy, int sx, int sy);
        send_beat(KIND_LOAD, pack_beat(idx, fx, fy, sx, sy));
    endtask

    task automatic send_query(int fx, int fy, int sx, int sy);
        send_beat(KIND_QUERY, pack_beat($urandom_range(15), fx, fy, sx, sy));
    endtask

    // stop sending and let every pending result come back, plus the block's tail
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_loss_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // setup cycle then access cycle; the register takes the value at the access edge
    task automatic write_walls_in_use(int v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WALLS_IN_USE;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        sb.walls_in_use = v & 31;
        settings_used++;
    endtask

    function automatic int clamp_coord(int v);
        return v < 0 ? 0 : (v > 1023 ? 1023 : v);
    endfunction

    // random query: mostly spanning paths, some near field, some along a wall
    task automatic random_query();
        int sel, fx, fy, w;
        sel = $urandom_range(99);
        fx = $urandom_range(1023);
        fy = $urandom_range(1023);
        if (sel < 10)
            send_query(fx, fy, clamp_coord(fx + $urandom_range(22) - 11),
                       clamp_coord(fy + $urandom_range(22) - 11));
        else if (sel < 20)
        begin
            // path on a wall's own line: parallel case
            w = $urandom_range(NWALLS - 1);
            if ($urandom_range(1))
                send_query(sb.wx1[w], sb.wy1[w], sb.wx2[w], sb.wy2[w]);
            else
                send_query(sb.wx2[w], sb.wy2[w], sb.wx1[w], sb.wy1[w]);
        end
        else
            send_query(fx, fy, $urandom_range(1023), $urandom_range(1023));
    endtask

    task automatic random_load();
        int sel, x, y;
        sel = $urandom_range(99);
        x = $urandom_range(1023);
        y = $urandom_range(1023);
        if (sel < 15)
            send_load($urandom_range(15), x, y, x, $urandom_range(1023));
        else if (sel < 30)
            send_load($urandom_range(15), x, y, $urandom_range(1023), y);
        else
            send_load($urandom_range(15), x, y, $urandom_range(1023), $urandom_range(1023));
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int phase_setting[6];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no walls in use yet: open-space slope, near-field edge
        send_query(0, 0, 1023, 1023);
        send_query(500, 500, 510, 500);
        send_query(500, 500, 510, 501);
        send_query(300, 300, 300, 300);

        // load walls 0 to 6, then nine loads at random indices, before any entry is tested
        send_load(0, 0, 512, 1023, 512);
        send_load(1, 512, 0, 512, 1023);
        send_load(2, 100, 100, 900, 900);
        send_load(3, 1023, 1023, 0, 0);
        send_load(4, 0, 0, 0, 0);
        send_load(5, 1023, 0, 0, 1023);
        send_load(6, 200, 700, 200, 700);
        for (int i = 7; i < NWALLS; i++)
            random_load();
        drain();
        write_walls_in_use(16);

        send_query(0, 0, 1023, 1023);
        send_query(1023, 0, 0, 1023);
        send_query(100, 100, 900, 900);
        send_query(50, 50, 400, 400);
        send_query(0, 512, 1023, 512);
        send_query(0, 0, 0, 1023);
        drain();

        // random phases through several register settings, extremes included
        phase_setting[0] = 0;
        phase_setting[1] = 16;
        phase_setting[2] = 31;
        phase_setting[3] = 1;
        phase_setting[4] = 17;
        phase_setting[5] = $urandom_range(31);
        for (int ph = 0; ph < 6; ph++)
        begin
            write_walls_in_use(phase_setting[ph]);
            idle_on = (ph != 2);
            for (int n = 0; n < 238; n++)
            begin
                if ($urandom_range(99) < 25)
                    random_load();
                else
                    random_query();
            end
            drain();
        end
        idle_on = 1'b1;

        $display("tb: %0d loads, %0d queries (%0d near field, %0d with walls crossed)",
                 sb.loads_seen, sb.queries_seen, sb.near_seen, sb.crossed_seen);
        $display("tb: %0d register settings, %0d mismatches",
                 settings_used, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_loss_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
src/mwpl_pkg.sv
src/mwpl_cross.sv
src/multi_wall_path_loss.sv
tb/multi_wall_path_loss_tb.sv
